>>> src/cmykdp_pkg.sv
// ----------------------------------------------------------------------------
// cmykdp_pkg - shared types and constants of the cmyk plane dither packer
// payload structs, queue entry, line geometry and register indexes
// ----------------------------------------------------------------------------
package cmykdp_pkg;

  localparam int MASK_SIZE_DEFAULT = 16;
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int MAX_HEIGHT        = 4096;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef enum logic [1:0] {
    PLANE_CYAN    = 2'd0,
    PLANE_MAGENTA = 2'd1,
    PLANE_YELLOW  = 2'd2,
    PLANE_BLACK   = 2'd3
  } plane_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TABLE = 1'b1
  } op_t;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] mask_row;
    logic [3:0] mask_col;
    logic [7:0] mask_value;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] packed_bits;
    logic       end_of_line;
  } pix_out_t;

  // one classified item on its way from front to back
  typedef struct packed {
    op_t         op;
    logic        direct;
    logic [7:0]  dval;
    logic [15:0] num;
    logic [7:0]  divisor;
    logic [7:0]  addr;
    logic [7:0]  value;
  } entry_t;

  typedef struct packed {
    logic [11:0] last_col;
    logic [11:0] last_row;
  } geom_t;

endpackage

>>> src/cmyk_plane_dither_packer_core.sv
// ----------------------------------------------------------------------------
// cmyk_plane_dither_packer_core - one ink plane as packed ordered-dither bits
// raster rgb pixels in, bytes of eight dithered pixels out
// ----------------------------------------------------------------------------
// usage
// - in channel (in_valid/in_ready/in_data): each transfer is either a pixel
//   (func 0) or a write of one threshold table entry (func 1); load the
//   table entries that the mask size covers before sending pixels
// - out channel (out_valid/out_ready/out_data): one transfer per eight
//   pixels and a last, possibly partial, one per line, leftmost pixel in bit 7
// - config port: plane select, line width and image height, written by
//   index with cfg_write_en; the user must write only while the block is idle, which the block does not enforce
// - in the back end a pixel passes through a table read, 8 restoring divider
//   steps and a pack step when the plane value needs the divide, and through
//   the table read and pack step alone for black plane or all-zero pixels
// - the serial divider sets the pixel rate; the two-entry queue lets the
//   front accept items while the back end is busy
// - a finished byte waits in the output register; the back end stalls only
//   when a further byte is due and the receiver has not taken the last one
// - reset clears position counters, bit accumulator, queue and output valid;
//   configuration returns to cyan, width 8, height 1; table contents are
//   undefined until written
// ----------------------------------------------------------------------------
module cmyk_plane_dither_packer_core
  import cmykdp_pkg::*;
#(
  parameter int MASK_SIZE = MASK_SIZE_DEFAULT,
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pix_out_t              out_data
);

  // front to queue
  logic   push_valid;
  logic   push_ready;
  entry_t push_data;

  // queue to back
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  // clamped line geometry from the config registers
  geom_t  geom;

  cmykdp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data),
    .geom         (geom)
  );

  cmykdp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cmykdp_back #(
    .MASK_SIZE (MASK_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/cmykdp_front.sv
// ----------------------------------------------------------------------------
// cmykdp_front - item intake and classification
// holds the configuration registers, picks the ink channel and forms the
// dividend of the plane value so the back end only has to divide
// ----------------------------------------------------------------------------
module cmykdp_front
  import cmykdp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pix_in_t               in_data,
  output logic                  push_valid,
  input  logic                  push_ready,
  output entry_t                push_data,
  output geom_t                 geom
);

  plane_t                plane_select;
  logic [CFG_DATA_W-1:0] line_width;
  logic [CFG_DATA_W-1:0] image_height;

  logic [7:0] mx;
  logic [7:0] ch;
  logic [7:0] diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_select <= PLANE_CYAN;
      line_width   <= CFG_DATA_W'(8);
      image_height <= CFG_DATA_W'(1);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_PLANE_SELECT: plane_select <= plane_t'(cfg_data[1:0]);
        CFG_LINE_WIDTH:   line_width   <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped geometry, held as index of the last column and last row
  always_comb begin
    if (line_width == '0) begin
      geom.last_col = '0;
    end else if (line_width > CFG_DATA_W'(MAX_WIDTH)) begin
      geom.last_col = 12'(MAX_WIDTH - 1);
    end else begin
      geom.last_col = 12'(line_width - CFG_DATA_W'(1));
    end
    if (image_height == '0) begin
      geom.last_row = '0;
    end else if (image_height > CFG_DATA_W'(MAX_HEIGHT)) begin
      geom.last_row = 12'(MAX_HEIGHT - 1);
    end else begin
      geom.last_row = 12'(image_height - CFG_DATA_W'(1));
    end
  end

  always_comb begin
    mx = in_data.red;
    if (in_data.green > mx) begin
      mx = in_data.green;
    end
    if (in_data.blue > mx) begin
      mx = in_data.blue;
    end
    unique case (plane_select)
      PLANE_CYAN:    ch = in_data.red;
      PLANE_MAGENTA: ch = in_data.green;
      default:       ch = in_data.blue;
    endcase
    diff = mx - ch;
  end

  always_comb begin
    push_data.op      = op_t'(in_data.func);
    // black plane and an all-zero pixel need no division
    push_data.direct  = (plane_select == PLANE_BLACK) || (mx == 8'd0);
    push_data.dval    = (plane_select == PLANE_BLACK) ? mx : 8'd0;
    // diff * 255 as diff * 256 - diff
    push_data.num     = {diff, 8'd0} - {8'd0, diff};
    push_data.divisor = mx;
    push_data.addr    = {in_data.mask_row, in_data.mask_col};
    push_data.value   = in_data.mask_value;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

>>> src/cmykdp_fifo.sv
// ----------------------------------------------------------------------------
// cmykdp_fifo - short queue between front and back
// lets intake and execution stall independently
// ----------------------------------------------------------------------------
module cmykdp_fifo
  import cmykdp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> src/cmykdp_back.sv
// ----------------------------------------------------------------------------
// cmykdp_back - execution of queued items
// threshold table, restoring divider, raster position and bit packing
// ----------------------------------------------------------------------------
module cmykdp_back
  import cmykdp_pkg::*;
#(
  parameter int MASK_SIZE = MASK_SIZE_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  geom_t    geom,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  entry_t   pop_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pix_out_t out_data
);

  localparam int MW = $clog2(MASK_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t          state;
  logic [2:0]      step;
  logic [7:0]      rem;
  logic [7:0]      quo;
  logic [7:0]      divisor;
  logic            direct;
  logic [7:0]      dval;
  logic [7:0]      thr;
  logic [7:0]      table_mem [256];
  logic [11:0]     col;
  logic [11:0]     row;
  logic [MW-1:0]   col_mod;
  logic [MW-1:0]   row_mod;
  logic [7:0]      acc;

  logic [8:0]      trial;
  logic            fits;
  logic [8:0]      trial_diff;
  logic [7:0]      plane_val;
  logic            pix_bit;
  logic [7:0]      acc_next;
  logic            last;
  logic            emit;
  logic            out_free;
  logic            send;
  logic            take;
  logic [7:0]      rd_addr;

  assign pop_ready = (state == ST_IDLE);
  assign take      = pop_valid && (state == ST_IDLE);
  assign rd_addr   = {4'(row_mod), 4'(col_mod)};

  // threshold table, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (take && pop_data.op == OP_TABLE) begin
      table_mem[pop_data.addr] <= pop_data.value;
    end
    if (take && pop_data.op == OP_PIXEL) begin
      thr <= table_mem[rd_addr];
    end
  end

  // one quotient bit per step
  always_comb begin
    trial      = {rem, quo[7]};
    fits       = (trial >= {1'b0, divisor});
    trial_diff = trial - {1'b0, divisor};
  end

  always_comb begin
    plane_val = direct ? dval : FULL_SCALE - quo;
    pix_bit   = (plane_val != 8'd0) && (plane_val >= thr);
    acc_next  = acc | (pix_bit ? (8'h80 >> col[2:0]) : 8'h00);
    last      = (col >= geom.last_col);
    emit      = last || (col[2:0] == 3'd7);
    out_free  = !out_valid || out_ready;
    // a finished byte goes to the output register this cycle
    send      = (state == ST_DONE) && emit && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
      col_mod   <= '0;
      row_mod   <= '0;
      acc       <= '0;
      step      <= '0;
    end else begin
      if (send) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take && pop_data.op == OP_PIXEL) begin
            rem     <= pop_data.num[15:8];
            quo     <= pop_data.num[7:0];
            divisor <= pop_data.divisor;
            direct  <= pop_data.direct;
            dval    <= pop_data.dval;
            step    <= '0;
            state   <= pop_data.direct ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= fits ? trial_diff[7:0] : trial[7:0];
          quo  <= {quo[6:0], fits};
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!emit || out_free) begin
            if (emit) begin
              out_data.packed_bits <= acc_next;
              out_data.end_of_line <= last;
              acc                  <= '0;
            end else begin
              acc <= acc_next;
            end
            if (last) begin
              col     <= '0;
              col_mod <= '0;
              if (row >= geom.last_row) begin
                row     <= '0;
                row_mod <= '0;
              end else begin
                row     <= row + 12'd1;
                row_mod <= (row_mod == MW'(MASK_SIZE - 1)) ? '0 : row_mod + MW'(1);
              end
            end else begin
              col     <= col + 12'd1;
              col_mod <= (col_mod == MW'(MASK_SIZE - 1)) ? '0 : col_mod + MW'(1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
